@@ rtl/tdt_pkg.sv @@
// Package for the tag detection tally table: item types, record and status codes,
// and the controller states. No dependencies.
`default_nettype none

package tdt_pkg;

  localparam int SERIAL_W    = 32;
  localparam int CODE_W      = 8;
  localparam int COUNT_W     = 16;
  localparam int TALLY_W     = 32;
  localparam int PERIOD_W    = 32;
  localparam int ENTRY_IDX_W = 5;

  localparam logic [COUNT_W-1:0]  COUNT_MAX      = 16'hFFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 32'd180000;

  typedef enum logic [1:0] {
    KIND_DETECT = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REC_STATUS = 2'd0,
    REC_HEADER = 2'd1,
    REC_ENTRY  = 2'd2
  } rec_kind_t;

  typedef enum logic [1:0] {
    CODE_COUNTED   = 2'd0,
    CODE_NEW       = 2'd1,
    CODE_SATURATED = 2'd2,
    CODE_DROPPED   = 2'd3
  } status_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_HIT,
    S_MISS,
    S_REP_HDR,
    S_REP_READ,
    S_REP_EMIT
  } fsm_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SERIAL_W-1:0] tag_serial;
    logic [CODE_W-1:0]   tag_freq;
    logic [CODE_W-1:0]   tag_channel;
    logic [CODE_W-1:0]   tag_letter;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             record_kind;
    logic [1:0]             status_code;
    logic [TALLY_W-1:0]     status_lines;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [SERIAL_W-1:0]    out_serial;
    logic [CODE_W-1:0]      out_freq;
    logic [CODE_W-1:0]      out_channel;
    logic [CODE_W-1:0]      out_letter;
    logic [COUNT_W-1:0]     hit_count;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [SERIAL_W-1:0] serial;
    logic [CODE_W-1:0]   freq;
    logic [CODE_W-1:0]   channel;
    logic [CODE_W-1:0]   letter;
    logic [COUNT_W-1:0]  count;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/tdt_chan_if.sv @@
// Valid/ready channel interface carrying one word of a chosen payload type.
// Used for the item, result and configuration channels; no dependencies.
`default_nettype none

interface tdt_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tag_detection_tally_table_unit.sv @@
// Tag detection tally table: one memory of entries searched and updated in place.
// Depends on tdt_pkg and tdt_chan_if.
//
// Channels: items (sink) takes detections, status-line notices and millisecond
// ticks; results (source) gives status, header and entry records; cfg (sink)
// writes the report period in milliseconds and is always ready.
// A detection scans the used entries one per cycle through the memory's single
// read port; a miss then loads one status word with last set into the output
// register once that register is free, and a hit, which does the same, can end
// the scan sooner. The next item is taken in the cycle after the word is loaded.
// Status lines and ticks that do not end a period give no word.
// A tick that reaches the period gives a header word, then one word per used
// entry, each read from memory and then emitted, the final word carrying last;
// the table, the status tally and the millisecond timer are then cleared.
// Items are taken one at a time: ready is high only while the controller idles.
// A stalled receiver holds the output register, and the controller waits
// before loading the next word; an accepted item's work runs meanwhile.
// Reset empties the table at once (a fill count, no clearing pass), zeroes
// the tally and timer and restores the default period of 180000 ms.
`default_nettype none

module tag_detection_tally_table_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire            clk,
  input  wire            rst,
  tdt_chan_if.sink       items,
  tdt_chan_if.source     results,
  tdt_chan_if.sink       cfg
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int EIW   = tdt_pkg::ENTRY_IDX_W;
  localparam int CW    = tdt_pkg::COUNT_W;
  localparam int TW    = tdt_pkg::TALLY_W;
  localparam int PW    = tdt_pkg::PERIOD_W;

  tdt_pkg::fsm_t      state, state_next;
  tdt_pkg::in_item_t  cur;
  tdt_pkg::out_item_t out_reg, out_next;
  tdt_pkg::entry_t    mem [TABLE_DEPTH];
  tdt_pkg::entry_t    rd_data, mem_wdata;

  logic             out_valid;
  logic [CNT_W-1:0] used, scan_idx;
  logic [IDX_W-1:0] cmp_idx, rep_idx, mem_waddr, mem_raddr;
  logic             cmp_vld;
  logic [TW-1:0]    tally;
  logic [PW-1:0]    elapsed, elapsed_inc, period;

  logic item_acc, out_free, out_load, mem_we, mem_re, rep_done;
  logic match, scan_done, table_full, rep_last, report_due, count_sat;

  assign item_acc   = items.valid && items.ready;
  assign out_free   = !out_valid || results.ready;
  assign items.ready = (state == tdt_pkg::S_IDLE);
  assign cfg.ready   = 1'b1;
  assign results.valid = out_valid;
  assign results.data  = out_reg;

  assign match = cmp_vld && (rd_data.serial == cur.tag_serial) &&
                 (rd_data.freq == cur.tag_freq) && (rd_data.channel == cur.tag_channel);
  assign scan_done   = (scan_idx >= used);
  assign table_full  = (used >= CNT_W'(TABLE_DEPTH));
  assign rep_last    = ((CNT_W'(rep_idx) + CNT_W'(1)) == used);
  assign count_sat   = (rd_data.count == tdt_pkg::COUNT_MAX);
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + PW'(1);
  assign report_due  = (elapsed_inc >= period);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tdt_pkg::S_IDLE: begin
        if (item_acc) begin
          if (items.data.kind == tdt_pkg::KIND_DETECT) begin
            state_next = tdt_pkg::S_SEARCH;
          end else if (items.data.kind == tdt_pkg::KIND_TICK && report_due) begin
            state_next = tdt_pkg::S_REP_HDR;
          end
        end
      end
      tdt_pkg::S_SEARCH: begin
        if (match) begin
          state_next = tdt_pkg::S_HIT;
        end else if (scan_done) begin
          state_next = tdt_pkg::S_MISS;
        end
      end
      tdt_pkg::S_HIT, tdt_pkg::S_MISS: begin
        if (out_free) state_next = tdt_pkg::S_IDLE;
      end
      tdt_pkg::S_REP_HDR: begin
        if (out_free) begin
          state_next = (used == '0) ? tdt_pkg::S_IDLE : tdt_pkg::S_REP_READ;
        end
      end
      tdt_pkg::S_REP_READ: state_next = tdt_pkg::S_REP_EMIT;
      tdt_pkg::S_REP_EMIT: begin
        if (out_free) state_next = rep_last ? tdt_pkg::S_IDLE : tdt_pkg::S_REP_READ;
      end
      default: state_next = tdt_pkg::S_IDLE;
    endcase
  end

  // Outputs: memory port controls and the next output word.
  always_comb begin
    out_load  = 1'b0;
    out_next  = '0;
    mem_we    = 1'b0;
    mem_waddr = cmp_idx;
    mem_wdata = rd_data;
    mem_re    = 1'b0;
    mem_raddr = rep_idx;
    rep_done  = 1'b0;
    unique case (state)
      tdt_pkg::S_SEARCH: begin
        mem_re    = !match && !scan_done;
        mem_raddr = scan_idx[IDX_W-1:0];
      end
      tdt_pkg::S_HIT: begin
        out_load                = out_free;
        out_next.record_kind    = tdt_pkg::REC_STATUS;
        out_next.status_code    = count_sat ? tdt_pkg::CODE_SATURATED : tdt_pkg::CODE_COUNTED;
        out_next.entry_index    = EIW'(cmp_idx);
        out_next.out_serial     = rd_data.serial;
        out_next.out_freq       = rd_data.freq;
        out_next.out_channel    = rd_data.channel;
        out_next.out_letter     = rd_data.letter;
        out_next.hit_count      = count_sat ? rd_data.count : rd_data.count + CW'(1);
        out_next.last           = 1'b1;
        mem_we                  = out_free;
        mem_wdata.count         = out_next.hit_count;
      end
      tdt_pkg::S_MISS: begin
        out_load             = out_free;
        out_next.record_kind = tdt_pkg::REC_STATUS;
        out_next.out_serial  = cur.tag_serial;
        out_next.out_freq    = cur.tag_freq;
        out_next.out_channel = cur.tag_channel;
        out_next.out_letter  = cur.tag_letter;
        out_next.last        = 1'b1;
        if (table_full) begin
          out_next.status_code = tdt_pkg::CODE_DROPPED;
        end else begin
          out_next.status_code = tdt_pkg::CODE_NEW;
          out_next.entry_index = EIW'(used);
          out_next.hit_count   = CW'(1);
          mem_we               = out_free;
        end
        mem_waddr         = used[IDX_W-1:0];
        mem_wdata.serial  = cur.tag_serial;
        mem_wdata.freq    = cur.tag_freq;
        mem_wdata.channel = cur.tag_channel;
        mem_wdata.letter  = cur.tag_letter;
        mem_wdata.count   = CW'(1);
      end
      tdt_pkg::S_REP_HDR: begin
        out_load              = out_free;
        out_next.record_kind  = tdt_pkg::REC_HEADER;
        out_next.status_lines = tally;
        out_next.last         = (used == '0);
        rep_done              = out_free && (used == '0);
      end
      tdt_pkg::S_REP_READ: begin
        mem_re = 1'b1;
      end
      tdt_pkg::S_REP_EMIT: begin
        out_load             = out_free;
        out_next.record_kind = tdt_pkg::REC_ENTRY;
        out_next.entry_index = EIW'(rep_idx);
        out_next.out_serial  = rd_data.serial;
        out_next.out_freq    = rd_data.freq;
        out_next.out_channel = rd_data.channel;
        out_next.out_letter  = rd_data.letter;
        out_next.hit_count   = rd_data.count;
        out_next.last        = rep_last;
        rep_done             = out_free && rep_last;
      end
      default: begin
      end
    endcase
  end

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdt_pkg::S_IDLE;
      out_valid <= 1'b0;
      used      <= '0;
      tally     <= '0;
      elapsed   <= '0;
      period    <= tdt_pkg::PERIOD_DEFAULT;
      cmp_vld   <= 1'b0;
      scan_idx  <= '0;
      rep_idx   <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) period <= cfg.data;

      if (item_acc && items.data.kind == tdt_pkg::KIND_STATUS) tally <= tally + TW'(1);
      if (item_acc && items.data.kind == tdt_pkg::KIND_TICK) elapsed <= elapsed_inc;

      // The compare stage is registered, so it trails the read address.
      if (state == tdt_pkg::S_SEARCH) begin
        cmp_vld <= mem_re;
        if (mem_re) begin
          cmp_idx  <= scan_idx[IDX_W-1:0];
          scan_idx <= scan_idx + CNT_W'(1);
        end
      end else begin
        cmp_vld  <= 1'b0;
        scan_idx <= '0;
      end

      if (state == tdt_pkg::S_MISS && out_free && !table_full) used <= used + CNT_W'(1);

      if (state == tdt_pkg::S_REP_HDR) begin
        rep_idx <= '0;
      end else if (state == tdt_pkg::S_REP_EMIT && out_free) begin
        rep_idx <= rep_idx + IDX_W'(1);
      end

      if (rep_done) begin
        used    <= '0;
        tally   <= '0;
        elapsed <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) cur <= items.data;
    if (out_load) out_reg <= out_next;
  end

  // The fill count never passes the table depth.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // Every memory write goes with a status word loaded in the same cycle.
  a_write_with_word: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (out_load && state == tdt_pkg::S_HIT) || (out_load && state == tdt_pkg::S_MISS))
    else $error("memory write without a status word");

  // While a hit waits for the receiver the read data still holds the matched key.
  a_hit_key_held: assert property (@(posedge clk) disable iff (rst)
    (state == tdt_pkg::S_HIT) |-> (rd_data.serial == cur.tag_serial &&
      rd_data.freq == cur.tag_freq && rd_data.channel == cur.tag_channel))
    else $error("matched entry lost before update");

  // Finishing a report leaves an empty table, a zero tally and a zero timer.
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    rep_done |=> (used == '0 && tally == '0 && elapsed == '0 &&
      state == tdt_pkg::S_IDLE))
    else $error("report did not clear the period state");

endmodule

`default_nettype wire

@@ tb/sv/tb_tag_detection_tally_table_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for tag_detection_tally_table_unit: a tally predictor class,
// tasks that drive the item and period channels and a stalling result receiver.
// Depends on tdt_pkg, tdt_chan_if and the unit itself.

import tdt_pkg::*;

class tag_tally_tracker;
  localparam int DEPTH = 32;

  logic [47:0]  keys    [DEPTH];
  logic [7:0]   letters [DEPTH];
  logic [15:0]  counts  [DEPTH];
  int unsigned  used;
  logic [31:0]  status_lines;
  logic [31:0]  elapsed_ms;
  logic [31:0]  period_ms;
  out_item_t    pending_records [$];
  int unsigned  errors;

  function new();
    used         = 0;
    status_lines = '0;
    elapsed_ms   = '0;
    period_ms    = PERIOD_DEFAULT;
    errors       = 0;
  endfunction

  function void set_period(logic [31:0] v);
    period_ms = v;
  endfunction

  function int pending();
    return pending_records.size();
  endfunction

  // Work out the records that one accepted word will cause.
  function void take_item(in_item_t it);
    out_item_t   r;
    logic [47:0] key;
    int          hit;
    r = '0;
    if (it.kind == KIND_DETECT) begin
      key = {it.tag_serial, it.tag_freq, it.tag_channel};
      hit = -1;
      for (int i = 0; i < used; i++) begin
        if (hit < 0 && keys[i] == key) hit = i;
      end
      r.record_kind = REC_STATUS;
      r.last        = 1'b1;
      r.out_serial  = it.tag_serial;
      r.out_freq    = it.tag_freq;
      r.out_channel = it.tag_channel;
      if (hit >= 0) begin
        if (counts[hit] != COUNT_MAX) begin
          counts[hit]   = counts[hit] + 16'd1;
          r.status_code = CODE_COUNTED;
        end else begin
          r.status_code = CODE_SATURATED;
        end
        r.entry_index = 5'(hit);
        r.out_letter  = letters[hit];
        r.hit_count   = counts[hit];
      end else if (used < DEPTH) begin
        keys[used]    = key;
        letters[used] = it.tag_letter;
        counts[used]  = 16'd1;
        r.status_code = CODE_NEW;
        r.entry_index = 5'(used);
        r.out_letter  = it.tag_letter;
        r.hit_count   = 16'd1;
        used++;
      end else begin
        // Table full: the detection is echoed back with index and count left at zero.
        r.status_code = CODE_DROPPED;
        r.out_letter  = it.tag_letter;
      end
      pending_records.push_back(r);
    end else if (it.kind == KIND_STATUS) begin
      status_lines = status_lines + 32'd1;
    end else if (it.kind == KIND_TICK) begin
      if (elapsed_ms != 32'hFFFF_FFFF) elapsed_ms = elapsed_ms + 32'd1;
      if (elapsed_ms >= period_ms) begin
        r.record_kind  = REC_HEADER;
        r.status_lines = status_lines;
        r.last         = (used == 0);
        pending_records.push_back(r);
        for (int i = 0; i < used; i++) begin
          r = '0;
          r.record_kind = REC_ENTRY;
          r.entry_index = 5'(i);
          {r.out_serial, r.out_freq, r.out_channel} = keys[i];
          r.out_letter  = letters[i];
          r.hit_count   = counts[i];
          r.last        = (i == used - 1);
          pending_records.push_back(r);
        end
        used         = 0;
        status_lines = '0;
        elapsed_ms   = '0;
      end
    end
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  function void match_record(out_item_t got);
    out_item_t want;
    if (pending_records.size() == 0) begin
      errors++;
      $display("%0t: record expected none, got %h", $time, got);
      return;
    end
    want = pending_records.pop_front();
    check_field("record_kind",  want.record_kind,  got.record_kind);
    check_field("status_code",  want.status_code,  got.status_code);
    check_field("status_lines", want.status_lines, got.status_lines);
    check_field("entry_index",  want.entry_index,  got.entry_index);
    check_field("out_serial",   want.out_serial,   got.out_serial);
    check_field("out_freq",     want.out_freq,     got.out_freq);
    check_field("out_channel",  want.out_channel,  got.out_channel);
    check_field("out_letter",   want.out_letter,   got.out_letter);
    check_field("hit_count",    want.hit_count,    got.hit_count);
    check_field("last",         want.last,         got.last);
  endfunction
endclass

module tb_tag_detection_tally_table_unit;

  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int          QUIET_CYCLES = 80;
  localparam int          HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;
  tag_tally_tracker sb;

  tdt_chan_if #(.T(in_item_t))              item_ch ();
  tdt_chan_if #(.T(out_item_t))             result_ch ();
  tdt_chan_if #(.T(logic [PERIOD_W-1:0]))   period_ch ();

  tag_detection_tally_table_unit dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .cfg     (period_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tag_detection_tally_table_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) sb.match_record(result_ch.data);
      if (item_ch.valid && item_ch.ready) sb.take_item(item_ch.data);
      if (period_ch.valid && period_ch.ready) sb.set_period(period_ch.data);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [47:0] fresh_key();
    return {$urandom, 16'($urandom)};
  endfunction

  function automatic in_item_t detection(logic [47:0] key, logic [7:0] letter);
    in_item_t it;
    it.kind = KIND_DETECT;
    {it.tag_serial, it.tag_freq, it.tag_channel} = key;
    it.tag_letter = letter;
    return it;
  endfunction

  // Non-detection words carry random payload, which the unit must ignore.
  function automatic in_item_t bare_item(logic [1:0] k);
    in_item_t it;
    it.kind        = k;
    it.tag_serial  = $urandom;
    it.tag_freq    = 8'($urandom);
    it.tag_channel = 8'($urandom);
    it.tag_letter  = 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_ch.data  <= it;
    item_ch.valid <= 1'b1;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Wait until every expected record has come and the controller has gone quiet.
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [31:0] v);
    period_ch.data  <= v;
    period_ch.valid <= 1'b1;
    @(posedge clk);
    while (!period_ch.ready) @(posedge clk);
    period_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] period, input int n, input int fresh_pct,
                           input bit gaps, input bit squeeze);
    logic [47:0] pool [8];
    logic [47:0] key;
    in_item_t    it;
    int          roll;
    int          sent;
    settle();
    write_period(period);
    idle_on = gaps;
    hold_req = squeeze;
    foreach (pool[i]) pool[i] = fresh_key();
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        if ($urandom_range(0, 99) < fresh_pct) key = fresh_key();
        else if ($urandom_range(0, 3) == 0)
          key = pool[$urandom_range(0, 7)] ^ (48'd1 << $urandom_range(0, 47));
        else key = pool[$urandom_range(0, 7)];
        it = detection(key, 8'($urandom));
      end else if (roll < 65) begin
        it = bare_item(KIND_STATUS);
      end else if (roll < 95) begin
        it = bare_item(KIND_TICK);
      end else begin
        it = bare_item(KIND_UNUSED);
      end
      send_item(it);
      if (it.kind != KIND_UNUSED) sent++;
    end
  endtask

  initial begin
    logic [47:0] hot_key;
    sb = new();
    item_ch.valid   <= 1'b0;
    item_ch.data    <= '0;
    period_ch.valid <= 1'b0;
    period_ch.data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default period: ticks, status lines and the unused kind give nothing.
    send_item(bare_item(KIND_TICK));
    send_item(bare_item(KIND_STATUS));
    send_item(bare_item(KIND_UNUSED));
    settle();
    write_period(32'd1);
    send_item(bare_item(KIND_TICK));
    send_item(detection(48'h0, 8'h00));
    send_item(detection(48'hFFFF_FFFF_FFFF, 8'hFF));
    // A hit reports the letter stored with the entry, not the new one.
    send_item(detection(48'hFFFF_FFFF_FFFF, 8'h00));
    send_item(detection(48'hFFFF_FFFF_FEFF, 8'h5A));
    send_item(detection(48'hFFFF_FFFF_FFFE, 8'hA5));
    send_item(detection(48'h0000_0001_0000, 8'h3C));
    send_item(detection(48'h0, 8'hFF));
    send_item(bare_item(KIND_STATUS));
    send_item(bare_item(KIND_STATUS));
    send_item(bare_item(KIND_TICK));
    send_item(bare_item(KIND_TICK));
    settle();
    write_period(32'hFFFF_FFFF);
    send_item(bare_item(KIND_TICK));
    send_item(bare_item(KIND_TICK));
    send_item(detection(48'h8000_0000_8080, 8'h81));

    // Fill the table past its depth so that later detections are dropped.
    for (int i = 0; i < 36; i++) send_item(detection(fresh_key(), 8'($urandom)));
    send_item(detection(48'h0, 8'h11));

    // The first tick at period one reports the full table into a stalled receiver.
    run_phase(32'd1, 60, 30, 1'b1, 1'b1);
    run_phase(32'($urandom_range(2, 8)), 70, 40, 1'b1, 1'b0);
    run_phase(32'($urandom_range(9, 40)), 80, 50, 1'b1, 1'b0);
    run_phase(32'($urandom_range(1, 4)), 70, 20, 1'b0, 1'b0);
    run_phase($urandom, 60, 30, 1'b1, 1'b0);

    // Last part without idling: flush, then count one entry up a few times.
    idle_on = 1'b0;
    settle();
    write_period(32'd1);
    send_item(bare_item(KIND_TICK));
    settle();
    write_period(32'hFFFF_FFFF);
    hot_key = fresh_key();
    for (int i = 0; i < 4; i++) send_item(detection(hot_key, 8'($urandom)));
    send_item(detection(~hot_key, 8'($urandom)));
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tag_detection_tally_table_unit verification clean");
    end else begin
      $display("tag_detection_tally_table_unit verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tdt_pkg.sv
rtl/tdt_chan_if.sv
rtl/tag_detection_tally_table_unit.sv
tb/sv/tb_tag_detection_tally_table_unit.sv
